### hdl/els_pkg.sv
// Shared types, widths and helpers for the edge list statistics block.
// No dependencies.
package els_pkg;

	localparam int ID_W   = 14;
	localparam int CNT_W  = 32;
	localparam int NODE_W = 15;

	localparam int ID_SPAN = 1 << ID_W;

	typedef logic [ID_W-1:0]   id_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [NODE_W-1:0] node_cnt_t;

	localparam cnt_t      CNT_MAX  = '1;
	localparam node_cnt_t NODE_MAX = '1;

	// One result item as it sits in the output queue.
	typedef struct packed {
		cnt_t      edges_seen;
		node_cnt_t distinct_nodes;
		cnt_t      source_runs;
		cnt_t      max_out_degree;
		id_t       lowest_id;
		id_t       highest_id;
	} stats_t;

	function automatic cnt_t sat_inc(input cnt_t v);
		return (v == CNT_MAX) ? v : v + cnt_t'(1);
	endfunction

endpackage

### hdl/edge_list_statistics.sv
// Edge list statistics: top level with the seen-node map, run tracking and output queue.
// Depends on els_pkg and els_ram.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one directed edge per item:
//   source_node and dest_node, edges grouped by source. Output channel
//   (out_valid / out_stall) returns one item of running statistics per edge.
//   An item is taken at a rising edge with valid high and stall low.
// Path: an accepted item is looked up in phase A (source), then in phase B
//   (destination), and its result then enters the output queue. The input side
//   takes no new item while one is in phase A. The seen-node map RAM has one read
//   port, so the two lookups of each edge are made one after the other.
// Reset: arst_n clears all counters and starts a clearing pass over the map,
//   one entry per cycle, NODE_COUNT entries (at most 16384) long. in_stall
//   stays high for that whole pass.
// Receiver stall: results wait in a two-entry output queue. The input side
//   takes an item only when the queue has room for everything in flight,
//   so a stall that lands while a result waits can delay the next item;
//   a longer stall fills the queue and then holds in_stall high.
// Ids at or above NODE_COUNT never touch the map and are not counted as
//   distinct, but still update lowest_id and highest_id.
module edge_list_statistics #(
	parameter int NODE_COUNT = 16384
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  els_pkg::id_t        source_node,
	input  els_pkg::id_t        dest_node,
	output logic                out_valid,
	input  logic                out_stall,
	output els_pkg::cnt_t       edges_seen,
	output els_pkg::node_cnt_t  distinct_nodes,
	output els_pkg::cnt_t       source_runs,
	output els_pkg::cnt_t       max_out_degree,
	output els_pkg::id_t        lowest_id,
	output els_pkg::id_t        highest_id
);

	import els_pkg::*;

	// Only ids that fit in the id field can ever reach the map.
	localparam int MapDepth = (NODE_COUNT < ID_SPAN) ? NODE_COUNT : ID_SPAN;
	localparam int AddrW    = $clog2(MapDepth);

	typedef logic [AddrW-1:0] addr_t;

	// ---------------------------------------------------------------
	// Clearing pass after reset
	// ---------------------------------------------------------------
	logic  clr_active_q;
	addr_t clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			if (clr_addr_q == addr_t'(MapDepth - 1)) begin
				clr_active_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + addr_t'(1);
		end
	end

	// ---------------------------------------------------------------
	// Sequencing: phase A looks up the source, phase B the destination
	// ---------------------------------------------------------------
	logic        ph_a_q;
	logic        ph_b_q;
	logic [1:0]  q_cnt_q;
	logic        in_accept;
	logic        out_pop;

	// Room check: the queue must hold everything that lands before it drains.
	assign in_stall  = clr_active_q || ph_a_q || (q_cnt_q == 2'd2)
		|| ((q_cnt_q == 2'd1) && ph_b_q);
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_a_q <= 1'b0;
			ph_b_q <= 1'b0;
		end else begin
			ph_a_q <= in_accept;
			ph_b_q <= ph_a_q;
		end
	end

	// Held item fields
	id_t   src_s1;
	id_t   dst_s1;
	logic  src_in_s1;
	logic  dst_in_s1;
	logic  src_in;
	logic  dst_in;

	assign src_in = 32'(source_node) < NODE_COUNT;
	assign dst_in = 32'(dest_node) < NODE_COUNT;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			src_s1    <= source_node;
			dst_s1    <= dest_node;
			src_in_s1 <= src_in;
			dst_in_s1 <= dst_in;
		end
	end

	// ---------------------------------------------------------------
	// Seen-node map: read, test, write back
	// ---------------------------------------------------------------
	logic  rd_en;
	addr_t rd_addr;
	logic  rd_bit;
	logic  wr_en;
	addr_t wr_addr;
	logic  wr_bit;

	logic  look_active;
	logic  look_in;
	addr_t look_addr;
	logic  look_hit;
	logic  look_new;

	logic  prev_wr_valid_q;
	addr_t prev_wr_addr_q;

	// Source is read at the accepting edge, destination at the next one.
	assign rd_en   = (in_accept && src_in) || (ph_a_q && dst_in_s1);
	assign rd_addr = ph_a_q ? dst_s1[AddrW-1:0] : source_node[AddrW-1:0];

	assign look_active = ph_a_q || ph_b_q;
	assign look_in     = ph_a_q ? src_in_s1 : dst_in_s1;
	assign look_addr   = ph_a_q ? src_s1[AddrW-1:0] : dst_s1[AddrW-1:0];

	// The lookup just before was written at the same edge this read happened,
	// so the RAM returned old data: forward its mark.
	assign look_hit = rd_bit || (prev_wr_valid_q && (prev_wr_addr_q == look_addr));
	assign look_new = look_active && look_in && !look_hit;

	assign wr_en   = clr_active_q || look_new;
	assign wr_addr = clr_active_q ? clr_addr_q : look_addr;
	assign wr_bit  = !clr_active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_wr_valid_q <= 1'b0;
		end else begin
			prev_wr_valid_q <= look_active && look_in;
		end
	end

	always_ff @(posedge clk) begin
		prev_wr_addr_q <= look_addr;
	end

	els_ram #(
		.WIDTH(1),
		.DEPTH(MapDepth)
	) u_seen_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_bit),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_bit)
	);

	// ---------------------------------------------------------------
	// Running statistics
	// ---------------------------------------------------------------
	id_t       run_source_q;
	logic      run_open_q;
	cnt_t      run_len_q;
	cnt_t      best_run_q;
	cnt_t      run_total_q;
	cnt_t      edge_total_q;
	node_cnt_t node_total_q;
	id_t       low_q;
	id_t       high_q;

	node_cnt_t node_next;
	id_t       low_ab;
	id_t       high_ab;

	assign node_next = (look_new && (node_total_q != NODE_MAX))
		? node_total_q + node_cnt_t'(1) : node_total_q;

	assign low_ab  = (src_s1 < dst_s1) ? src_s1 : dst_s1;
	assign high_ab = (src_s1 > dst_s1) ? src_s1 : dst_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_source_q <= '0;
			run_open_q   <= 1'b0;
			run_len_q    <= '0;
			best_run_q   <= '0;
			run_total_q  <= '0;
			edge_total_q <= '0;
			node_total_q <= '0;
			low_q        <= '1;
			high_q       <= '0;
		end else begin
			// distinct count advances in both phases
			node_total_q <= node_next;
			if (ph_a_q) begin
				// first edge always opens a run, whatever its source
				if (!run_open_q || (src_s1 != run_source_q)) begin
					if (run_open_q && (run_len_q > best_run_q)) begin
						best_run_q <= run_len_q;
					end
					run_total_q  <= sat_inc(run_total_q);
					run_source_q <= src_s1;
					run_len_q    <= cnt_t'(1);
					run_open_q   <= 1'b1;
				end else begin
					run_len_q <= sat_inc(run_len_q);
				end
				if (low_ab < low_q) begin
					low_q <= low_ab;
				end
				if (high_ab > high_q) begin
					high_q <= high_ab;
				end
				edge_total_q <= sat_inc(edge_total_q);
			end
		end
	end

	// Result of the item in phase B; the open run counts toward the maximum.
	stats_t result;

	always_comb begin
		result.edges_seen     = edge_total_q;
		result.distinct_nodes = node_next;
		result.source_runs    = run_total_q;
		result.max_out_degree = (run_len_q > best_run_q) ? run_len_q : best_run_q;
		result.lowest_id      = low_q;
		result.highest_id     = high_q;
	end

	// ---------------------------------------------------------------
	// Two-entry output queue
	// ---------------------------------------------------------------
	stats_t head_q;
	stats_t tail_q;
	logic   push;

	assign push    = ph_b_q;
	assign out_pop = (q_cnt_q != 2'd0) && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_cnt_q <= 2'd0;
		end else begin
			q_cnt_q <= q_cnt_q + {1'b0, push} - {1'b0, out_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push && ((q_cnt_q == 2'd0) || ((q_cnt_q == 2'd1) && out_pop))) begin
			head_q <= result;
		end else if (out_pop) begin
			head_q <= tail_q;
		end
		if (push && (((q_cnt_q == 2'd1) && !out_pop) || ((q_cnt_q == 2'd2) && out_pop))) begin
			tail_q <= result;
		end
	end

	assign out_valid      = (q_cnt_q != 2'd0);
	assign edges_seen     = head_q.edges_seen;
	assign distinct_nodes = head_q.distinct_nodes;
	assign source_runs    = head_q.source_runs;
	assign max_out_degree = head_q.max_out_degree;
	assign lowest_id      = head_q.lowest_id;
	assign highest_id     = head_q.highest_id;

endmodule

### hdl/els_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module els_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-during-write to the same entry returns the old data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### dv/edge_list_statistics_tb.sv
// Self-checking testbench for edge_list_statistics: streams directed edges, predicts the
// running statistics of each one and checks every result item as it leaves the block.
// Depends on els_pkg and the edge_list_statistics RTL.
module edge_list_statistics_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import els_pkg::*;

	localparam int MAP_NODES   = 16384;
	localparam int PHASE_ITEMS = 150;
	// Reset clears the map one entry per cycle, so the quiet limit lies well beyond MAP_NODES.
	localparam int STALL_LIMIT = 80000;

	typedef struct {
		id_t src;
		id_t dst;
	} arc_t;

	logic      clk;
	logic      arst_n      = 1'b0;
	logic      in_valid    = 1'b0;
	logic      in_stall;
	id_t       source_node = '0;
	id_t       dest_node   = '0;
	logic      out_valid;
	logic      out_stall   = 1'b0;
	cnt_t      edges_seen;
	node_cnt_t distinct_nodes;
	cnt_t      source_runs;
	cnt_t      max_out_degree;
	id_t       lowest_id;
	id_t       highest_id;

	edge_list_statistics #(
		.NODE_COUNT(MAP_NODES)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.source_node    (source_node),
		.dest_node      (dest_node),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.edges_seen     (edges_seen),
		.distinct_nodes (distinct_nodes),
		.source_runs    (source_runs),
		.max_out_degree (max_out_degree),
		.lowest_id      (lowest_id),
		.highest_id     (highest_id)
	);

	// Edges waiting to be driven, and the statistics expected for edges already taken.
	arc_t   arc_queue[$];
	stats_t pending_stats[$];

	int mismatch_count = 0;
	int items_taken    = 0;
	int idle_cycles    = 0;
	int idle_phase;
	int send_gap_pct;
	int stall_pct;

	// Running statistics as the block should hold them, starting from the reset state.
	bit        seen_node [MAP_NODES];
	id_t       cur_source     = '0;
	bit        run_is_open    = 1'b0;
	cnt_t      cur_run_len    = '0;
	cnt_t      longest_closed = '0;
	cnt_t      runs_started   = '0;
	node_cnt_t nodes_found    = '0;
	cnt_t      edges_taken    = '0;
	id_t       lo_id          = '1;
	id_t       hi_id          = '0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Mark a node on first sight and bump the distinct count; ids past the map are ignored.
	function automatic void mark_seen(input id_t id);
		if (int'(id) < MAP_NODES && !seen_node[id]) begin
			seen_node[id] = 1'b1;
			if (nodes_found != NODE_MAX)
				nodes_found++;
		end
	endfunction

	// Fold one taken edge into the running statistics and return what the block should show.
	function automatic stats_t tally_edge(input id_t src, input id_t dst);
		stats_t s;
		mark_seen(src);
		mark_seen(dst);
		if (!run_is_open || src != cur_source) begin
			// New run: close the previous one into the best so far, restart at length one.
			if (run_is_open && cur_run_len > longest_closed)
				longest_closed = cur_run_len;
			if (runs_started != CNT_MAX)
				runs_started++;
			cur_source  = src;
			cur_run_len = cnt_t'(1);
			run_is_open = 1'b1;
		end else if (cur_run_len != CNT_MAX) begin
			cur_run_len++;
		end
		if (src < lo_id) lo_id = src;
		if (dst < lo_id) lo_id = dst;
		if (src > hi_id) hi_id = src;
		if (dst > hi_id) hi_id = dst;
		if (edges_taken != CNT_MAX)
			edges_taken++;
		s.edges_seen     = edges_taken;
		s.distinct_nodes = nodes_found;
		s.source_runs    = runs_started;
		// The open run counts toward the maximum as well.
		s.max_out_degree = (cur_run_len > longest_closed) ? cur_run_len : longest_closed;
		s.lowest_id      = lo_id;
		s.highest_id     = hi_id;
		return s;
	endfunction

	task automatic check_field(input string label, input cnt_t want, input cnt_t got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
			mismatch_count++;
		end
	endtask

	task automatic add_arc(input id_t src, input id_t dst);
		arc_t a;
		a.src = src;
		a.dst = dst;
		arc_queue.insert(arc_queue.size(), a);
	endtask

	// Pick a node id: from a small pool (so nodes repeat) or anywhere about equally often, else at the ends.
	function automatic id_t pick_node();
		int roll;
		roll = $urandom_range(99);
		if (roll < 45)
			return id_t'($urandom_range(63));
		else if (roll < 90)
			return id_t'($urandom);
		else
			return ($urandom_range(1)) ? '1 : '0;
	endfunction

	// Cycle through the idling phases as items are taken: none, sender gaps,
	// receiver stalls, both lightly, then none again.
	always_comb begin
		idle_phase = (items_taken / PHASE_ITEMS) % 5;
		unique case (idle_phase)
			1: begin
				send_gap_pct = 53;
				stall_pct    = 0;
			end
			2: begin
				send_gap_pct = 0;
				stall_pct    = 53;
			end
			3: begin
				send_gap_pct = 14;
				stall_pct    = 14;
			end
			default: begin
				send_gap_pct = 0;
				stall_pct    = 0;
			end
		endcase
	end

	// Driver: predict on every taken item, then load the next edge when the slot is free.
	// Hold the payload while the block stalls.
	always @(posedge clk) begin : drive_arcs
		arc_t   nxt;
		stats_t want_next;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				want_next = tally_edge(source_node, dest_node);
				pending_stats.insert(pending_stats.size(), want_next);
				items_taken <= items_taken + 1;
			end
			if (!in_valid || !in_stall) begin
				if (arc_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					nxt = arc_queue.pop_front();
					in_valid    <= 1'b1;
					source_node <= nxt.src;
					dest_node   <= nxt.dst;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each taken result against the oldest expectation, then roll the stall.
	always @(posedge clk) begin : watch_results
		stats_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_stats.size() == 0) begin
					$display("%0t ns: result item with nothing expected, edges_seen %0d",
						$time, edges_seen);
					mismatch_count++;
				end else begin
					want = pending_stats.pop_front();
					check_field("edges_seen", want.edges_seen, edges_seen);
					check_field("distinct_nodes", cnt_t'(want.distinct_nodes),
						cnt_t'(distinct_nodes));
					check_field("source_runs", want.source_runs, source_runs);
					check_field("max_out_degree", want.max_out_degree, max_out_degree);
					check_field("lowest_id", cnt_t'(want.lowest_id), cnt_t'(lowest_id));
					check_field("highest_id", cnt_t'(want.highest_id), cnt_t'(highest_id));
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog: end the run once nothing has moved on either side for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		id_t src;
		int  run_len;
		int  roll;

		// Directed part. The first edge opens a run even though its source is node 0;
		// it is also a self-loop, so only one node becomes distinct.
		add_arc('0, '0);
		add_arc('0, '1);
		add_arc('0, 14'd1);
		// New run from the top id; the closed run of three becomes the best.
		add_arc('1, '0);
		add_arc('1, '1);
		add_arc(14'h2AAA, 14'h1555);
		add_arc(14'h1555, 14'h2AAA);
		add_arc(14'd5, 14'd6);
		add_arc(14'd5, 14'd5);
		// Back to source 0 out of order: a fresh run over nodes already seen.
		add_arc('0, 14'd6);
		// Long open run: the maximum must follow it before it closes.
		for (int i = 0; i < 6; i++)
			add_arc(14'd9, id_t'(100 + i));
		add_arc(14'd7, 14'd9);
		add_arc(14'h2000, 14'h0001);
		add_arc(14'h0001, 14'h2000);
		add_arc(14'h3FFE, 14'h3FFE);

		// Random part: mostly grouped runs with random content, the rest single noise edges.
		while (arc_queue.size() < 1830) begin
			roll = $urandom_range(99);
			if (roll < 85) begin
				src  = pick_node();
				roll = $urandom_range(99);
				if (roll < 80)
					run_len = $urandom_range(6, 1);
				else if (roll < 95)
					run_len = $urandom_range(30, 7);
				else
					run_len = $urandom_range(80, 31);
				for (int i = 0; i < run_len; i++)
					add_arc(src, ($urandom_range(9) == 0) ? src : pick_node());
			end else begin
				add_arc(id_t'($urandom), id_t'($urandom));
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: wait for every edge to be taken and every result to come back.
		while (arc_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (pending_stats.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatch_count == 0 && pending_stats.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
